/* rtl/core/fixed_point_sine_cosine_poly_macros.svh */
// assertion macros for the sine / cosine polynomial core
// no dependencies; included by the files that carry assertions
`ifndef FIXED_POINT_SINE_COSINE_POLY_MACROS_SVH
`define FIXED_POINT_SINE_COSINE_POLY_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication in the same cycle
`define SCP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sine/cosine core: same-cycle check failed");

// implication into the next cycle
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sine/cosine core: next-cycle check failed");

`else

`define SCP_ASSERT_SAME(label, clk, rst, ante, cons)
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/scp_pkg.sv */
// constants for the sine / cosine polynomial core
// no dependencies; used by fixed_point_sine_cosine_poly and its bench
package scp_pkg;

   localparam int ANGLE_W = 16;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 20;
   localparam int PROD_W  = 2 * SUM_W;

   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   // odd series for sine
   localparam logic signed [SUM_W-1:0] SIN_S1 = 20'sh06488;
   localparam logic signed [SUM_W-1:0] SIN_S3 = 20'sh02958;
   localparam logic signed [SUM_W-1:0] SIN_S5 = 20'sh0051a;
   localparam logic signed [SUM_W-1:0] SIN_S7 = 20'sh0004d;

   // even series for cosine
   localparam logic signed [SUM_W-1:0] COS_C0 = 20'sh07fff;
   localparam logic signed [SUM_W-1:0] COS_C2 = 20'sh04ef5;
   localparam logic signed [SUM_W-1:0] COS_C4 = 20'sh0103e;
   localparam logic signed [SUM_W-1:0] COS_C6 = 20'sh00156;

endpackage

/* rtl/core/fixed_point_sine_cosine_poly.sv */
// sine / cosine by horner polynomials, five-stage pipeline with per-stage stall
// depends on scp_pkg and fixed_point_sine_cosine_poly_macros.svh
//
// channel | dir | tdata          | tuser
// req     | in  | angle [15:0]   | operation (0 sine, 1 cosine)
// rsp     | out | value [15:0]   | -
//
// one beat per cycle sustained while rsp_tready stays high
// stages: square, three multiply-subtract horner steps, final scale
// each stage holds when its successor is full and stalled; bubbles are squeezed out
// synchronous reset empties the pipeline; payload registers are not reset
`include "fixed_point_sine_cosine_poly_macros.svh"

module fixed_point_sine_cosine_poly (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // angle[15:0]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // value[15:0]
);

   localparam int NSTAGE = 5;
   localparam int SW     = scp_pkg::SUM_W;
   localparam int PW     = scp_pkg::PROD_W;
   localparam int AW     = scp_pkg::ANGLE_W;
   localparam int FW     = AW + SW;

   logic [NSTAGE-1:0] valid_ff, valid_in, adv;

   logic [NSTAGE-2:0]          op_ff;
   logic signed [AW-1:0]       angle_ff [NSTAGE-1];
   logic signed [SW-1:0]       z_ff [NSTAGE-2];
   logic signed [SW-1:0]       sum1_ff, sum2_ff, sum3_ff;
   logic signed [SW-1:0]       z_in, sum1_in, sum2_in, sum3_in;
   logic [scp_pkg::VALUE_W-1:0] value_ff, value_in;

   logic signed [2*AW-1:0]     sq;
   logic signed [PW-1:0]       p1, p2, p3;
   logic signed [FW-1:0]       p4;

   // stall chain
   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   // datapath
   always_comb begin
      sq      = $signed(req_tdata) * $signed(req_tdata);
      z_in    = SW'(sq >>> 12);
      p1      = z_ff[0] * ((op_ff[0] == scp_pkg::OP_COSINE) ? scp_pkg::COS_C6
                                                             : scp_pkg::SIN_S7);
      sum1_in = ((op_ff[0] == scp_pkg::OP_COSINE) ? scp_pkg::COS_C4 : scp_pkg::SIN_S5)
                - SW'(p1 >>> 16);
      p2      = z_ff[1] * sum1_ff;
      sum2_in = ((op_ff[1] == scp_pkg::OP_COSINE) ? scp_pkg::COS_C2 : scp_pkg::SIN_S3)
                - SW'(p2 >>> 16);
      p3      = z_ff[2] * sum2_ff;
      if (op_ff[2] == scp_pkg::OP_COSINE) begin
         sum3_in = scp_pkg::COS_C0 - SW'(p3 >>> 15);
      end else begin
         sum3_in = scp_pkg::SIN_S1 - SW'(p3 >>> 16);
      end
      p4 = angle_ff[3] * sum3_ff;
      if (op_ff[3] == scp_pkg::OP_COSINE) begin
         value_in = sum3_ff[scp_pkg::VALUE_W-1:0];
      end else begin
         value_in = p4[scp_pkg::VALUE_W+12:13];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         op_ff[0]    <= req_tuser;
         angle_ff[0] <= $signed(req_tdata);
         z_ff[0]     <= z_in;
      end
      for (int k = 1; k < NSTAGE - 1; k++) begin
         if (adv[k]) begin
            op_ff[k]    <= op_ff[k-1];
            angle_ff[k] <= angle_ff[k-1];
         end
      end
      for (int k = 1; k < NSTAGE - 2; k++) begin
         if (adv[k]) begin
            z_ff[k] <= z_ff[k-1];
         end
      end
      if (adv[1]) begin
         sum1_ff <= sum1_in;
      end
      if (adv[2]) begin
         sum2_ff <= sum2_in;
      end
      if (adv[3]) begin
         sum3_ff <= sum3_in;
      end
      if (adv[4]) begin
         value_ff <= value_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = value_ff;

   // an empty first stage always takes a beat
   `SCP_ASSERT_SAME(a_empty_ready, clock, reset, !valid_ff[0], req_tready)
   // the square of the angle is never negative
   `SCP_ASSERT_SAME(a_square_sign, clock, reset, valid_ff[0], !z_ff[0][SW-1])
   // a stalled stage keeps its item
   `SCP_ASSERT_NEXT(a_hold_mid, clock, reset, valid_ff[3] && !adv[3], valid_ff[3])
   // an item moving on reaches the next stage
   `SCP_ASSERT_NEXT(a_move_mid, clock, reset, valid_ff[2] && adv[3], valid_ff[3])

endmodule

/* bench/fixed_point_sine_cosine_poly_tb.sv */
// self-checking bench for the sine / cosine polynomial core: directed and random angle beats
// with random gaps on both streams, each result checked against a horner-form predictor
// depends on scp_pkg and fixed_point_sine_cosine_poly
module fixed_point_sine_cosine_poly_tb;

   typedef struct packed {
      logic        op;
      logic [15:0] angle;
   } angle_beat_type;

   typedef struct packed {
      logic        op;
      logic [15:0] angle;
      logic [15:0] value;
   } value_beat_type;

   localparam longint SINE_K1 = 64'sh6488;
   localparam longint SINE_K3 = 64'sh2958;
   localparam longint SINE_K5 = 64'sh051a;
   localparam longint SINE_K7 = 64'sh004d;
   localparam longint COSINE_K0 = 64'sh7fff;
   localparam longint COSINE_K2 = 64'sh4ef5;
   localparam longint COSINE_K4 = 64'sh103e;
   localparam longint COSINE_K6 = 64'sh0156;
   localparam int     RANDOM_BEATS = 1300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // angle[15:0]
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // value[15:0]

   angle_beat_type angle_queue[$];
   value_beat_type value_queue[$];
   logic        req_fire = 1'b0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          calm_left = 0;
   logic        calm = 1'b0;
   int          mismatch_count = 0;

   fixed_point_sine_cosine_poly DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // odd or even horner series, exact 64-bit intermediates, wrapped to 16 bits
   function automatic logic [15:0] poly_value(logic op, logic signed [15:0] angle);
      longint a;
      longint z;
      longint acc;
      a = angle;
      z = (a * a) >>> 12;
      if (op == scp_pkg::OP_SINE) begin
         acc = SINE_K7;
         acc = SINE_K5 - ((z * acc) >>> 16);
         acc = SINE_K3 - ((z * acc) >>> 16);
         acc = SINE_K1 - ((z * acc) >>> 16);
         acc = (a * acc) >>> 13;
      end else begin
         acc = COSINE_K6;
         acc = COSINE_K4 - ((z * acc) >>> 16);
         acc = COSINE_K2 - ((z * acc) >>> 16);
         acc = COSINE_K0 - ((z * acc) >>> 15);
      end
      return acc[15:0];
   endfunction

   // mostly no gap, some short ones, a few long; none while calm
   function automatic int pick_gap(logic quiet);
      if (quiet || $urandom_range(0, 9) < 6)
         return 0;
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (calm_left > 0) begin
         calm_left <= calm_left - 1;
      end else begin
         calm <= ~calm;
         calm_left <= $urandom_range(20, 150);
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (angle_queue.size() > 0) begin
            req_tuser <= angle_queue[0].op;
            req_tdata <= angle_queue[0].angle;
            void'(angle_queue.pop_front());
            req_tvalid <= 1'b1;
            req_gap <= pick_gap(calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap <= pick_gap(calm);
      end
   end

   // monitor
   always @(posedge clock) begin
      value_beat_type exp_beat;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            value_queue.push_back('{req_tuser, req_tdata, poly_value(req_tuser, req_tdata)});
         if (rsp_tvalid && rsp_tready) begin
            if (value_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected rsp beat: value %h", rsp_tdata);
            end else begin
               exp_beat = value_queue.pop_front();
               if (rsp_tdata !== exp_beat.value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: op %0d angle %h expected %h actual %h",
                              exp_beat.op, exp_beat.angle, exp_beat.value, rsp_tdata);
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (angle_queue.size() > 0 || (req_tvalid && !req_fire) || value_queue.size() > 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic add_random(int count);
      angle_beat_type beat;
      repeat (count) begin
         beat.op = $urandom_range(0, 1) ? scp_pkg::OP_COSINE : scp_pkg::OP_SINE;
         if ($urandom_range(0, 9) < 7)
            beat.angle = 16'($signed($urandom_range(0, 25736)) - 12868);
         else
            beat.angle = 16'($urandom_range(0, 16'hffff));
         angle_queue.push_back(beat);
      end
   endtask

   initial begin
      logic [15:0] corner_angles[11];
      corner_angles = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h5555,
                        16'haaaa, 16'd6434, -16'sd6434, 16'd12868, 16'd100};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (corner_angles[i]) begin
         angle_queue.push_back('{scp_pkg::OP_SINE, corner_angles[i]});
         angle_queue.push_back('{scp_pkg::OP_COSINE, corner_angles[i]});
      end
      wait_drained();
      add_random(RANDOM_BEATS / 2);
      wait_drained();
      add_random(RANDOM_BEATS - RANDOM_BEATS / 2);
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && value_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* fixed_point_sine_cosine_poly.f */
+incdir+rtl/core
rtl/core/scp_pkg.sv
rtl/core/fixed_point_sine_cosine_poly.sv
bench/fixed_point_sine_cosine_poly_tb.sv
